// File: sv/linear_hash_dedup_defines.svh
`ifndef LINEAR_HASH_DEDUP_DEFINES_SVH
`define LINEAR_HASH_DEDUP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define LHD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lhd assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define LHD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lhd assertion failed");

`endif

// File: sv/lhd_pkg.sv
package lhd_pkg;

    localparam int MAX_BUCKETS_D      = 256;
    localparam int SLOTS_PER_BUCKET_D = 32;
    localparam int KEY_BITS_D         = 32;

    localparam int IN_KEY_W  = 32;
    localparam int CAP_W     = 5;
    localparam int LP_W      = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;
    localparam int STATUS_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_PERCENT    = 2'd1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd4;
    localparam logic [LP_W-1:0]  LP_RESET  = 7'd75;
    localparam int               PCT_SCALE = 100;

    typedef enum logic [STATUS_W-1:0] {
        ST_DUP  = 2'd0,
        ST_NEW  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

endpackage

// File: sv/linear_hash_dedup.sv
// Duplicate filter over a linear-hashing table. Pulse start with i_key while busy is low;
// exactly one result (o_key_out, o_status) follows, shown for one cycle under o_strobe,
// and must be taken then: there is no back-pressure. Before the result, the key's bucket
// is scanned through at most fill slots, where fill is the slot count of its bucket (up to
// SLOTS_PER_BUCKET), read one slot a cycle from the key memory. Each bucket split also reads
// every slot of the split bucket through the same single key-memory read port. busy
// stays high from the cycle after acceptance through the result cycle, and the next start
// is taken no earlier than the cycle after the result. No clearing pass after reset.
// Configuration is taken at any time through i_cfg_valid (o_cfg_ready is always high) and
// must only change while busy is low.
module linear_hash_dedup #(
    parameter int MAX_BUCKETS      = lhd_pkg::MAX_BUCKETS_D,
    parameter int SLOTS_PER_BUCKET = lhd_pkg::SLOTS_PER_BUCKET_D,
    parameter int KEY_BITS         = lhd_pkg::KEY_BITS_D
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [lhd_pkg::IN_KEY_W-1:0] i_key,
    output logic                                o_strobe,
    output logic signed [lhd_pkg::IN_KEY_W-1:0] o_key_out,
    output logic [lhd_pkg::STATUS_W-1:0]        o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lhd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lhd_pkg::CFG_DAT_W-1:0]       i_cfg_data
);
    import lhd_pkg::*;

    localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int MW    = BKT_W + 1;
    localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
    localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int SW    = $clog2(SLOTS_PER_BUCKET);
    localparam int DEPTH = MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam int AW    = $clog2(DEPTH);
    localparam int REC_W = $clog2(DEPTH + 1);
    localparam int KW    = (KEY_BITS > BKT_W) ? KEY_BITS : BKT_W;
    localparam int LC_W  = CAP_W + LP_W;
    localparam int CMP_W = ((REC_W + 7) > (LC_W + CNT_W)) ? (REC_W + 7) : (LC_W + CNT_W);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_FILL = 9'b000000010,
        S_SCAN = 9'b000000100,
        S_CHK  = 9'b000001000,
        S_SRD  = 9'b000010000,
        S_MOVE = 9'b000100000,
        S_WFN  = 9'b001000000,
        S_OUT  = 9'b010000000,
        S_SPARE = 9'b100000000
    } t_state;

    function automatic logic [AW-1:0] slot_addr(input logic [BKT_W-1:0] b,
                                                input logic [FW-1:0] s);
        logic [AW+BKT_W-1:0] a;
        a = (AW+BKT_W)'(b) * (AW+BKT_W)'(SLOTS_PER_BUCKET) + (AW+BKT_W)'(s);
        return a[AW-1:0];
    endfunction

    logic [KEY_BITS-1:0] r_kmem [DEPTH];
    logic [FW-1:0]       r_fmem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] r_fvld;

    t_state              n_state;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic signed [IN_KEY_W-1:0] r_raw, n_raw;
    t_status             r_status, n_status;
    logic [BKT_W-1:0]    r_bkt, n_bkt;
    logic [BKT_W-1:0]    r_src, n_src;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [MW-1:0]       r_mod, n_mod;
    logic [MW-1:0]       r_nmod, n_nmod;
    logic [REC_W-1:0]    r_rec, n_rec;
    logic [FW-1:0]       r_cnt, n_cnt;
    logic [FW-1:0]       r_iss, n_iss;
    logic                r_pend, n_pend;
    logic [FW-1:0]       r_wsrc, n_wsrc;
    logic [FW-1:0]       r_wn, n_wn;
    logic [CAP_W-1:0]    r_cap;
    logic [LP_W-1:0]     r_lp;
    logic [LC_W-1:0]     r_lpcap;

    logic [KEY_BITS-1:0] r_kq;
    logic [FW-1:0]       r_fq;
    logic                r_fvq;

    logic                w_kwe;
    logic [AW-1:0]       w_kwa, w_kra;
    logic [KEY_BITS-1:0] w_kwd;
    logic                w_fwe;
    logic [BKT_W-1:0]    w_fwa, w_fra;
    logic [FW-1:0]       w_fwd;

    logic [KEY_BITS-1:0] w_kin;
    logic [KW-1:0]       w_kinx, w_kqx;
    logic [BKT_W-1:0]    w_idx, w_home, w_dst_lo, w_n;
    logic [MW-1:0]       w_nm;
    logic [FW-1:0]       w_f;
    logic [CMP_W-1:0]    w_lhs, w_rhs;
    logic                w_over, w_hit, w_issue;

    t_state r_state;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = (r_state == S_OUT);
    assign o_key_out   = r_raw;
    assign o_status    = r_status;

    assign w_kin  = KEY_BITS'(i_key);
    assign w_kinx = KW'(w_kin);
    assign w_kqx  = KW'(r_kq);
    assign w_idx  = w_kinx[BKT_W-1:0] & BKT_W'(r_mod - MW'(1));
    assign w_home = (CNT_W'(w_idx) >= r_count) ? (w_idx - BKT_W'(r_mod >> 1)) : w_idx;
    assign w_n    = r_count[BKT_W-1:0];
    assign w_nm   = (MW'(r_count) + MW'(1) > r_mod) ? (r_mod << 1) : r_mod;
    assign w_dst_lo = w_kqx[BKT_W-1:0] & BKT_W'(r_nmod - MW'(1));
    assign w_f    = r_fvq ? r_fq : '0;
    assign w_lhs  = CMP_W'(r_rec) * CMP_W'(PCT_SCALE);
    assign w_rhs  = CMP_W'(r_lpcap * (LC_W + CNT_W)'(r_count));
    assign w_over = (w_lhs >= w_rhs) && (r_count < CNT_W'(MAX_BUCKETS));
    assign w_hit  = r_pend && (r_kq == r_key);
    assign w_issue = (r_iss < r_cnt);

    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_raw    = r_raw;
        n_status = r_status;
        n_bkt    = r_bkt;
        n_src    = r_src;
        n_count  = r_count;
        n_mod    = r_mod;
        n_nmod   = r_nmod;
        n_rec    = r_rec;
        n_cnt    = r_cnt;
        n_iss    = r_iss;
        n_pend   = r_pend;
        n_wsrc   = r_wsrc;
        n_wn     = r_wn;
        w_kwe    = 1'b0;
        w_kwa    = '0;
        w_kwd    = r_key;
        w_kra    = slot_addr(r_bkt, r_iss);
        w_fwe    = 1'b0;
        w_fwa    = r_bkt;
        w_fwd    = '0;
        w_fra    = w_home;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key   = w_kin;
                    n_raw   = i_key;
                    n_bkt   = w_home;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_cnt   = w_f;
                n_iss   = '0;
                n_pend  = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                w_kra  = slot_addr(r_bkt, r_iss);
                n_pend = w_issue;
                if (w_issue) begin
                    n_iss = r_iss + FW'(1);
                end
                if (w_hit) begin
                    n_status = ST_DUP;
                    n_state  = S_OUT;
                end else if (!w_issue && !r_pend) begin
                    if (r_cnt == FW'(SLOTS_PER_BUCKET)) begin
                        n_status = ST_FULL;
                        n_state  = S_OUT;
                    end else begin
                        w_kwe    = 1'b1;
                        w_kwa    = slot_addr(r_bkt, r_cnt);
                        w_fwe    = 1'b1;
                        w_fwa    = r_bkt;
                        w_fwd    = r_cnt + FW'(1);
                        n_rec    = r_rec + REC_W'(1);
                        n_status = ST_NEW;
                        n_state  = S_CHK;
                    end
                end
            end
            S_CHK: begin
                n_nmod = w_nm;
                n_src  = w_n - BKT_W'(w_nm >> 1);
                w_fra  = w_n - BKT_W'(w_nm >> 1);
                n_state = w_over ? S_SRD : S_OUT;
            end
            S_SRD: begin
                n_cnt   = w_f;
                n_iss   = '0;
                n_pend  = 1'b0;
                n_wsrc  = '0;
                n_wn    = '0;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                w_kra  = slot_addr(r_src, r_iss);
                n_pend = w_issue;
                if (w_issue) begin
                    n_iss = r_iss + FW'(1);
                end
                w_kwd = r_kq;
                if (r_pend) begin
                    w_kwe = 1'b1;
                    if (w_dst_lo == w_n) begin
                        w_kwa = slot_addr(w_n, r_wn);
                        n_wn  = r_wn + FW'(1);
                    end else begin
                        w_kwa  = slot_addr(r_src, r_wsrc);
                        n_wsrc = r_wsrc + FW'(1);
                    end
                end
                if (!w_issue && !r_pend) begin
                    w_fwe   = 1'b1;
                    w_fwa   = r_src;
                    w_fwd   = r_wsrc;
                    n_state = S_WFN;
                end
            end
            S_WFN: begin
                w_fwe   = 1'b1;
                w_fwa   = w_n;
                w_fwd   = r_wn;
                n_count = r_count + CNT_W'(1);
                n_mod   = r_nmod;
                n_state = S_CHK;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CNT_W'(2);
            r_mod   <= MW'(2);
            r_rec   <= '0;
            r_cap   <= CAP_RESET;
            r_lp    <= LP_RESET;
            r_fvld  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_mod   <= n_mod;
            r_rec   <= n_rec;
            if (w_fwe) begin
                r_fvld[w_fwa] <= 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_BUCKET_CAPACITY: r_cap <= i_cfg_data[CAP_W-1:0];
                    REG_LOAD_PERCENT:    r_lp  <= i_cfg_data[LP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_raw    <= n_raw;
        r_status <= n_status;
        r_bkt    <= n_bkt;
        r_src    <= n_src;
        r_nmod   <= n_nmod;
        r_cnt    <= n_cnt;
        r_iss    <= n_iss;
        r_pend   <= n_pend;
        r_wsrc   <= n_wsrc;
        r_wn     <= n_wn;
        r_lpcap  <= LC_W'(r_lp) * LC_W'(r_cap);
        r_fvq    <= r_fvld[w_fra];
    end

    always_ff @(posedge i_clk) begin
        if (w_kwe) begin
            r_kmem[w_kwa] <= w_kwd;
        end
        r_kq <= r_kmem[w_kra];
    end

    always_ff @(posedge i_clk) begin
        if (w_fwe) begin
            r_fmem[w_fwa] <= w_fwd;
        end
        r_fq <= r_fmem[w_fra];
    end

endmodule

// File: sv/lhd_chk.sv
`include "linear_hash_dedup_defines.svh"

module lhd_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_strobe,
    input logic [lhd_pkg::STATUS_W-1:0] o_status
);
    import lhd_pkg::*;

    `LHD_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `LHD_ASSERT_IMP(a_strobe_busy, o_strobe, busy)
    `LHD_ASSERT_NXT(a_strobe_free, o_strobe, !busy && !o_strobe)
    `LHD_ASSERT_IMP(a_status_code, o_strobe, o_status <= ST_FULL)

endmodule

bind linear_hash_dedup lhd_chk u_lhd_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_status (o_status)
);
